@@ hw/rtl/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants of the point-in-triangle test: the default coordinate
// width used by the input channel interface and the top level.
// ----------------------------------------------------------------------------
package pit_pkg;

  // Signed fixed-point coordinate, 8 fraction bits
  localparam int unsigned PitCoordWidth = 16;

endpackage

@@ hw/rtl/pit_if.sv @@
// ----------------------------------------------------------------------------
// pit_if
// Valid/ready channels of the point-in-triangle test: one word of three
// triangle corners and a query point in, one word of two flags out.
// ----------------------------------------------------------------------------
interface pit_in_if import pit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = PitCoordWidth
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] c_z;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
           point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
           point_x, point_y, point_z,
    output ready
  );
endinterface

interface pit_out_if ();
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (output valid, inside_res, degenerate, input ready);
  modport sink   (input valid, inside_res, degenerate, output ready);
endinterface

@@ hw/rtl/point_in_triangle_test.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Exact barycentric point-in-triangle test in 3D on fixed-point corners.
// ----------------------------------------------------------------------------
// Usage:
//   pts_i carries one word per query: corners a, b, c and point p, each
//   coordinate COORD_WIDTH bits signed. res_o returns one word per query:
//   inside_res and degenerate, in the order the queries were accepted.
//   A zero Gram determinant sets degenerate and clears inside_res.
// Throughput: one query per cycle while res_o does not stall. Seven register
//   stages: differences, coordinate products, dot products, partial products
//   of the split dot products, product assembly, determinant and numerators,
//   final compare.
// Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out; a stall on res_o fills the pipe and pts_i.ready
//   drops only once all seven stages hold a word.
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module point_in_triangle_test import pit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = PitCoordWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pit_in_if.sink    pts_i,
  pit_out_if.source res_o
);

  localparam int unsigned NSTAGE = 7;
  localparam int unsigned NPROD  = 6;
  localparam int unsigned DIFF_W = COORD_WIDTH + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned DOT_W  = SQ_W + 2;
  localparam int unsigned LO_W   = (DOT_W + 1) / 2;
  localparam int unsigned HI_W   = DOT_W - LO_W;
  localparam int unsigned HH_W   = 2 * HI_W;
  localparam int unsigned MID_W  = DOT_W;
  localparam int unsigned LL_W   = 2 * LO_W;
  localparam int unsigned PROD_W = 2 * DOT_W;
  localparam int unsigned RES_W  = PROD_W + 1;
  localparam int unsigned CMP_W  = RES_W + 2;

  // Stage control
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v_q[NSTAGE-1] || res_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pts_i.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign pts_i.ready = en[0];

  // Stage 0: edge vectors and point offset
  logic signed [COORD_WIDTH-1:0] a_c [3];
  logic signed [COORD_WIDTH-1:0] b_c [3];
  logic signed [COORD_WIDTH-1:0] c_c [3];
  logic signed [COORD_WIDTH-1:0] p_c [3];
  logic signed [DIFF_W-1:0]      e0_d [3];
  logic signed [DIFF_W-1:0]      e1_d [3];
  logic signed [DIFF_W-1:0]      q_d  [3];
  logic signed [DIFF_W-1:0]      e0_q [3];
  logic signed [DIFF_W-1:0]      e1_q [3];
  logic signed [DIFF_W-1:0]      q_q  [3];

  always_comb begin
    a_c[0] = pts_i.a_x;     a_c[1] = pts_i.a_y;     a_c[2] = pts_i.a_z;
    b_c[0] = pts_i.b_x;     b_c[1] = pts_i.b_y;     b_c[2] = pts_i.b_z;
    c_c[0] = pts_i.c_x;     c_c[1] = pts_i.c_y;     c_c[2] = pts_i.c_z;
    p_c[0] = pts_i.point_x; p_c[1] = pts_i.point_y; p_c[2] = pts_i.point_z;
    for (int k = 0; k < 3; k++) begin
      e0_d[k] = DIFF_W'(b_c[k]) - DIFF_W'(a_c[k]);
      e1_d[k] = DIFF_W'(c_c[k]) - DIFF_W'(a_c[k]);
      q_d[k]  = DIFF_W'(p_c[k]) - DIFF_W'(a_c[k]);
    end
  end

  // Stage 1: per-coordinate products
  logic signed [SQ_W-1:0] p00_d [3];
  logic signed [SQ_W-1:0] p01_d [3];
  logic signed [SQ_W-1:0] p11_d [3];
  logic signed [SQ_W-1:0] p20_d [3];
  logic signed [SQ_W-1:0] p21_d [3];
  logic signed [SQ_W-1:0] p00_q [3];
  logic signed [SQ_W-1:0] p01_q [3];
  logic signed [SQ_W-1:0] p11_q [3];
  logic signed [SQ_W-1:0] p20_q [3];
  logic signed [SQ_W-1:0] p21_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p00_d[k] = SQ_W'(e0_q[k]) * SQ_W'(e0_q[k]);
      p01_d[k] = SQ_W'(e0_q[k]) * SQ_W'(e1_q[k]);
      p11_d[k] = SQ_W'(e1_q[k]) * SQ_W'(e1_q[k]);
      p20_d[k] = SQ_W'(q_q[k])  * SQ_W'(e0_q[k]);
      p21_d[k] = SQ_W'(q_q[k])  * SQ_W'(e1_q[k]);
    end
  end

  // Stage 2: dot products
  logic signed [DOT_W-1:0] d00_d, d01_d, d11_d, d20_d, d21_d;
  logic signed [DOT_W-1:0] d00_q, d01_q, d11_q, d20_q, d21_q;

  assign d00_d = DOT_W'(p00_q[0]) + DOT_W'(p00_q[1]) + DOT_W'(p00_q[2]);
  assign d01_d = DOT_W'(p01_q[0]) + DOT_W'(p01_q[1]) + DOT_W'(p01_q[2]);
  assign d11_d = DOT_W'(p11_q[0]) + DOT_W'(p11_q[1]) + DOT_W'(p11_q[2]);
  assign d20_d = DOT_W'(p20_q[0]) + DOT_W'(p20_q[1]) + DOT_W'(p20_q[2]);
  assign d21_d = DOT_W'(p21_q[0]) + DOT_W'(p21_q[1]) + DOT_W'(p21_q[2]);

  // Stage 3: split each dot product into a signed high and an unsigned low
  // half and form the four partial products of every pair
  logic [DOT_W-1:0] opa [NPROD];
  logic [DOT_W-1:0] opb [NPROD];
  logic [HH_W-1:0]  hh_d [NPROD];
  logic [MID_W-1:0] hl_d [NPROD];
  logic [MID_W-1:0] lh_d [NPROD];
  logic [LL_W-1:0]  ll_d [NPROD];
  logic [HH_W-1:0]  hh_q [NPROD];
  logic [MID_W-1:0] hl_q [NPROD];
  logic [MID_W-1:0] lh_q [NPROD];
  logic [LL_W-1:0]  ll_q [NPROD];

  // Pairs: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
  always_comb begin
    opa[0] = d00_q; opb[0] = d11_q;
    opa[1] = d01_q; opb[1] = d01_q;
    opa[2] = d11_q; opb[2] = d20_q;
    opa[3] = d01_q; opb[3] = d21_q;
    opa[4] = d00_q; opb[4] = d21_q;
    opa[5] = d01_q; opb[5] = d20_q;
    for (int i = 0; i < NPROD; i++) begin
      hh_d[i] = HH_W'($signed(opa[i][DOT_W-1:LO_W]))
              * HH_W'($signed(opb[i][DOT_W-1:LO_W]));
      hl_d[i] = MID_W'($signed(opa[i][DOT_W-1:LO_W])) * MID_W'(opb[i][LO_W-1:0]);
      lh_d[i] = MID_W'(opa[i][LO_W-1:0]) * MID_W'($signed(opb[i][DOT_W-1:LO_W]));
      ll_d[i] = LL_W'(opa[i][LO_W-1:0]) * LL_W'(opb[i][LO_W-1:0]);
    end
  end

  // Stage 4: assemble the full products
  logic [PROD_W-1:0] prod_d [NPROD];
  logic [PROD_W-1:0] prod_q [NPROD];

  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      prod_d[i] = (PROD_W'($signed(hh_q[i])) << LL_W)
                + ((PROD_W'($signed(hl_q[i])) + PROD_W'($signed(lh_q[i]))) << LO_W)
                + PROD_W'(ll_q[i]);
    end
  end

  // Stage 5: Gram determinant and barycentric numerators
  logic [RES_W-1:0] den_d, nv_d, nw_d;
  logic [RES_W-1:0] den_q, nv_q, nw_q;

  assign den_d = RES_W'($signed(prod_q[0])) - RES_W'($signed(prod_q[1]));
  assign nv_d  = RES_W'($signed(prod_q[2])) - RES_W'($signed(prod_q[3]));
  assign nw_d  = RES_W'($signed(prod_q[4])) - RES_W'($signed(prod_q[5]));

  // Stage 6: exact inside test, nv + nw <= den without division
  logic [CMP_W-1:0] slack;
  logic             degen_d, inside_d;
  logic             degen_q, inside_q;

  always_comb begin
    slack    = CMP_W'($signed(den_q))
             - (CMP_W'($signed(nv_q)) + CMP_W'($signed(nw_q)));
    degen_d  = (den_q == '0);
    inside_d = !degen_d && !nv_q[RES_W-1] && !nw_q[RES_W-1] && !slack[CMP_W-1];
  end

  // Payload registers: advance with their stage, hold otherwise
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e0_q <= e0_d;
      e1_q <= e1_d;
      q_q  <= q_d;
    end
    if (en[1]) begin
      p00_q <= p00_d;
      p01_q <= p01_d;
      p11_q <= p11_d;
      p20_q <= p20_d;
      p21_q <= p21_d;
    end
    if (en[2]) begin
      d00_q <= d00_d;
      d01_q <= d01_d;
      d11_q <= d11_d;
      d20_q <= d20_d;
      d21_q <= d21_d;
    end
    if (en[3]) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      ll_q <= ll_d;
    end
    if (en[4]) begin
      prod_q <= prod_d;
    end
    if (en[5]) begin
      den_q <= den_d;
      nv_q  <= nv_d;
      nw_q  <= nw_d;
    end
    if (en[6]) begin
      degen_q  <= degen_d;
      inside_q <= inside_d;
    end
  end

  assign res_o.valid      = v_q[NSTAGE-1];
  assign res_o.inside_res = inside_q;
  assign res_o.degenerate = degen_q;

  // Assertions
  a_accept_enters : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pts_i.valid && pts_i.ready) |=> v_q[0]
  ) else $error("accepted word did not enter the first stage");

  a_full_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !pts_i.ready |-> (res_o.valid && !res_o.ready && (&v_q))
  ) else $error("input stalled while the pipeline had room");

  a_den_nonneg : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> !den_q[RES_W-1]
  ) else $error("Gram determinant came out negative");

  a_degen_excl : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.inside_res && res_o.degenerate)
  ) else $error("degenerate triangle reported inside");

endmodule

@@ dv/point_in_triangle_test_tb.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test_tb
// Self-checking bench for the barycentric point-in-triangle test. A short
// table of hand-picked triangles (degenerate, extremes, vertices, edges, off
// the plane) runs first, then random queries built mostly around real
// triangles, with random stalls on both channels and one long output stall.
// Typed rows check hand-set verdicts, all others an exact wide-integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_triangle_test_tb import pit_pkg::*; ();

  localparam int RandomQueries = 850;
  localparam int CalmQueries   = 120;
  localparam int HoldOffCycles = 60;
  localparam int DrainCycles   = 20;
  localparam int StallLimit    = 1000;

  typedef logic signed [PitCoordWidth-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    coord_t [2:0] p;
  } tri_query_t;

  typedef struct packed {
    logic hit;
    logic degen;
  } verdict_t;

  typedef struct packed {
    tri_query_t q;
    logic       typed;
    verdict_t   want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pit_in_if #(.COORD_WIDTH(PitCoordWidth)) pts ();
  pit_out_if res ();

  point_in_triangle_test #(.COORD_WIDTH(PitCoordWidth)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pts_i (pts),
    .res_o (res)
  );

  always #5 clk_i = ~clk_i;

  stim_row_t dir_tab[$];
  verdict_t  verdicts_q[$];
  verdict_t  got_verdict;
  int        fail_count = 0;
  int        stall_count = 0;
  int        gap_pct = 25;
  bit        calm = 1'b0;
  bit        hold_off_req = 1'b0;
  bit        hold_off_active = 1'b0;
  bit        hold_off_done = 1'b0;

  // Exact test: all products held in 128 bits, far beyond the worst case
  function automatic verdict_t judge_point(tri_query_t q);
    wide_t    e0[3];
    wide_t    e1[3];
    wide_t    dq[3];
    wide_t    av, bv, cv, pv;
    wide_t    d00, d01, d11, d20, d21, den, nv, nw;
    verdict_t v;
    d00 = '0; d01 = '0; d11 = '0; d20 = '0; d21 = '0;
    for (int k = 0; k < 3; k++) begin
      av = $signed(q.a[k]);
      bv = $signed(q.b[k]);
      cv = $signed(q.c[k]);
      pv = $signed(q.p[k]);
      e0[k] = bv - av;
      e1[k] = cv - av;
      dq[k] = pv - av;
      d00 += e0[k] * e0[k];
      d01 += e0[k] * e1[k];
      d11 += e1[k] * e1[k];
      d20 += dq[k] * e0[k];
      d21 += dq[k] * e1[k];
    end
    den = d00 * d11 - d01 * d01;
    nv  = d11 * d20 - d01 * d21;
    nw  = d00 * d21 - d01 * d20;
    v.degen = (den == 0);
    v.hit   = !v.degen && (nv >= 0) && (nw >= 0) && (nv + nw <= den);
    return v;
  endfunction

  function automatic tri_query_t corners(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, int px, int py, int pz);
    tri_query_t q;
    q.a[0] = coord_t'(ax); q.a[1] = coord_t'(ay); q.a[2] = coord_t'(az);
    q.b[0] = coord_t'(bx); q.b[1] = coord_t'(by); q.b[2] = coord_t'(bz);
    q.c[0] = coord_t'(cx); q.c[1] = coord_t'(cy); q.c[2] = coord_t'(cz);
    q.p[0] = coord_t'(px); q.p[1] = coord_t'(py); q.p[2] = coord_t'(pz);
    return q;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(tri_query_t q, logic typed, verdict_t want);
    stim_row_t row;
    row.q     = q;
    row.typed = typed;
    row.want  = want;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic int pick(int mag);
    return int'($urandom_range(0, 2 * mag + 1)) - mag - 1;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic tri_query_t make_query();
    tri_query_t q;
    int av[3], bv[3], cv[3], pv[3];
    int kind, mag, shape, s, t;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       mag = 255;
      1:       mag = 4095;
      default: mag = 32767;
    endcase
    if (kind < 30) begin
      // raw noise across the whole coordinate range
      for (int k = 0; k < 3; k++) begin
        q.a[k] = coord_t'($urandom); q.b[k] = coord_t'($urandom);
        q.c[k] = coord_t'($urandom); q.p[k] = coord_t'($urandom);
      end
      return q;
    end
    if (kind < 40) mag = (mag > 8191) ? 8191 : mag;
    for (int k = 0; k < 3; k++) begin
      av[k] = pick(mag);
      bv[k] = pick(mag);
      cv[k] = pick(mag);
    end
    shape = $urandom_range(0, 5);
    s = $urandom_range(0, 320) - 32;
    t = $urandom_range(0, 320) - 32;
    for (int k = 0; k < 3; k++) begin
      if (kind < 40) begin
        // collapse the triangle: repeated corner or a collinear third corner
        case (shape % 3)
          0:       cv[k] = bv[k];
          1:       cv[k] = av[k];
          default: cv[k] = 2 * bv[k] - av[k];
        endcase
        pv[k] = pick(mag);
      end else if (kind < 55) begin
        case (shape)
          0:       pv[k] = av[k];
          1:       pv[k] = bv[k];
          2:       pv[k] = cv[k];
          3:       pv[k] = (av[k] + bv[k]) >>> 1;
          4:       pv[k] = (bv[k] + cv[k]) >>> 1;
          default: pv[k] = (av[k] + cv[k]) >>> 1;
        endcase
      end else begin
        // weights in 1/256 steps, some a little past the edges
        pv[k] = av[k] + ((s * (bv[k] - av[k]) + t * (cv[k] - av[k])) >>> 8);
        if (shape < 2) pv[k] += pick(mag / 4);
      end
      q.a[k] = coord_t'(av[k]);
      q.b[k] = coord_t'(bv[k]);
      q.c[k] = clamp_coord(cv[k]);
      q.p[k] = clamp_coord(pv[k]);
    end
    return q;
  endfunction

  task automatic offer(input tri_query_t q, input verdict_t want);
    if ($urandom_range(0, 39) == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
    if (!calm && !hold_off_active && $urandom_range(0, 99) < gap_pct) begin
      pts.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pts.valid   <= 1'b1;
    pts.a_x     <= q.a[0]; pts.a_y <= q.a[1]; pts.a_z <= q.a[2];
    pts.b_x     <= q.b[0]; pts.b_y <= q.b[1]; pts.b_z <= q.b[2];
    pts.c_x     <= q.c[0]; pts.c_y <= q.c[1]; pts.c_z <= q.c[2];
    pts.point_x <= q.p[0]; pts.point_y <= q.p[1]; pts.point_z <= q.p[2];
    @(posedge clk_i);
    while (!pts.ready) @(posedge clk_i);
    verdicts_q.insert(verdicts_q.size(), want);
  endtask

  initial begin : stimulus
    tri_query_t q;
    verdict_t   no_hit;
    verdict_t   degen_hit;
    verdict_t   vertex_hit;
    no_hit     = '{hit: 1'b0, degen: 1'b0};
    degen_hit  = '{hit: 1'b0, degen: 1'b1};
    vertex_hit = '{hit: 1'b1, degen: 1'b0};

    // degenerate triangles: flag set, never inside
    add_row(corners(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, degen_hit);
    add_row(corners(32767, 32767, 32767, 32767, 32767, 32767,
                    32767, 32767, 32767, 32767, 32767, 32767), 1'b1, degen_hit);
    add_row(corners(-32768, -32768, -32768, -32768, -32768, -32768,
                    -32768, -32768, -32768, -32768, -32768, -32768), 1'b1, degen_hit);
    add_row(corners(0, 0, 0, 256, 256, 256, 512, 512, 512, 0, 0, 0), 1'b1, degen_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 256, 0, 0, 128, 0, 0), 1'b1, degen_hit);
    add_row(corners(-32768, 32767, 0, 32767, -32768, 0, -32768, 32767, 0,
                    0, 0, 0), 1'b1, degen_hit);
    // unit right triangle in the xy plane
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0), 1'b1, vertex_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 129, 128, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, -1, 0, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 10000), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 0, 256, 0, 256, 0, 0, 64, 64, -10000), 1'b0, no_hit);
    // one-LSB triangle
    add_row(corners(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0), 1'b0, no_hit);
    add_row(corners(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0), 1'b0, no_hit);
    // full-scale corners
    add_row(corners(-32768, -32768, -32768, 32767, -32768, -32768,
                    -32768, 32767, -32768, -32768, -32768, -32768), 1'b1, vertex_hit);
    add_row(corners(-32768, -32768, -32768, 32767, -32768, -32768,
                    -32768, 32767, -32768, 32767, 32767, 32767), 1'b0, no_hit);
    add_row(corners(-32768, -32768, -32768, 32767, -32768, -32768,
                    -32768, 32767, -32768, -32768, 32767, 32767), 1'b0, no_hit);
    add_row(corners(32767, 32767, 32767, -32768, 32767, 32767,
                    32767, -32768, 32767, 0, 0, -32768), 1'b0, no_hit);
    add_row(corners(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768,
                    0, 0, 0), 1'b0, no_hit);
    add_row(corners(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768,
                    32767, 32767, 32767), 1'b0, no_hit);

    rst_ni      <= 1'b0;
    pts.valid   <= 1'b0;
    pts.a_x     <= '0; pts.a_y <= '0; pts.a_z <= '0;
    pts.b_x     <= '0; pts.b_y <= '0; pts.b_z <= '0;
    pts.c_x     <= '0; pts.c_y <= '0; pts.c_z <= '0;
    pts.point_x <= '0; pts.point_y <= '0; pts.point_z <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      offer(dir_tab[i].q, dir_tab[i].typed ? dir_tab[i].want : judge_point(dir_tab[i].q));
    end

    hold_off_req = 1'b1;
    for (int n = 0; n < RandomQueries; n++) begin
      if (n == RandomQueries - CalmQueries) calm = 1'b1;
      q = make_query();
      offer(q, judge_point(q));
    end
    pts.valid <= 1'b0;

    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : sink_pacing
    res.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // hold the output long enough for the pipe to fill and push back
        hold_off_active = 1'b1;
        res.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        res.ready <= 1'b1;
        hold_off_active = 1'b0;
        hold_off_done   = 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 48 : 4)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (verdicts_q.size() == 0) begin
        fail_count++;
        $display("%0t: result word with nothing expected: inside %0b degenerate %0b",
                 $realtime, res.inside_res, res.degenerate);
      end else begin
        got_verdict = verdicts_q.pop_front();
        if (res.inside_res !== got_verdict.hit) begin
          fail_count++;
          $display("%0t: inside_res expected %0b actual %0b",
                   $realtime, got_verdict.hit, res.inside_res);
        end
        if (res.degenerate !== got_verdict.degen) begin
          fail_count++;
          $display("%0t: degenerate expected %0b actual %0b",
                   $realtime, got_verdict.degen, res.degenerate);
        end
      end
    end
  end

  // Advance the stall count on cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pts.valid && pts.ready) || (res.valid && res.ready)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

endmodule
